@@ src/assert_macros.svh @@
// Assertion macros for the RTL of the battery level monitor.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

`endif

@@ src/blm_pkg.sv @@
// Package with widths, register indexes and reset values of the battery level monitor.
package blm_pkg;

   localparam int SampleWidth  = 12;
   localparam int SumWidth     = 15;  // five 12-bit samples
   localparam int ScaledWidth  = 24;  // sum * 480 stays below 2^24
   localparam int MvWidth      = 16;
   localparam int LevelWidth   = 3;
   localparam int CountWidth   = 8;
   localparam int NumSamples   = 5;
   localparam int CsrIdxWidth  = 3;

   typedef logic [MvWidth-1:0]     mv_type;
   typedef logic [LevelWidth-1:0]  level_type;
   typedef logic [CountWidth-1:0]  count_type;
   typedef logic [SampleWidth-1:0] sample_type;

   // Register indexes of the configuration port.
   localparam logic [CsrIdxWidth-1:0] CSR_SHUTDOWN     = 3'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_LOW_ALARM    = 3'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_LEVEL1       = 3'd2;
   localparam logic [CsrIdxWidth-1:0] CSR_LEVEL2       = 3'd3;
   localparam logic [CsrIdxWidth-1:0] CSR_LEVEL3       = 3'd4;
   localparam logic [CsrIdxWidth-1:0] CSR_FULL         = 3'd5;
   localparam logic [CsrIdxWidth-1:0] CSR_FULL_CNT_PIN = 3'd6;
   localparam logic [CsrIdxWidth-1:0] CSR_FULL_CNT     = 3'd7;

   // Register reset values.
   localparam mv_type    RST_SHUTDOWN     = 16'd3200;
   localparam mv_type    RST_LOW_ALARM    = 16'd3400;
   localparam mv_type    RST_LEVEL1       = 16'd3600;
   localparam mv_type    RST_LEVEL2       = 16'd3700;
   localparam mv_type    RST_LEVEL3       = 16'd3850;
   localparam mv_type    RST_FULL         = 16'd4050;
   localparam count_type RST_FULL_CNT_PIN = 8'd3;
   localparam count_type RST_FULL_CNT     = 8'd10;

   // Levels.
   localparam level_type LEVEL_0     = 3'd0;
   localparam level_type LEVEL_1     = 3'd1;
   localparam level_type LEVEL_2     = 3'd2;
   localparam level_type LEVEL_3     = 3'd3;
   localparam level_type LEVEL_4     = 3'd4;
   localparam level_type LEVEL_NONE  = 3'd5;  // nothing reported yet

   localparam mv_type    MV_MAX      = 16'hFFFF;
   localparam count_type COUNT_MAX   = 8'hFF;

endpackage

@@ src/battery_level_monitor.sv @@
// Battery level monitor: serial voltage computation, level quantizing and charge tracking.
//
// One request word carries five 12-bit battery samples and one sample of the
// internal 1.2 V reference. The block adds the five samples one per cycle,
// scales the sum by 480 with a shift-and-subtract, and divides by the
// reference sample with a restoring divider that retires one quotient bit per
// cycle. The voltage in millivolts saturates at 65535 (also when the reference
// sample is zero). The voltage is quantized to levels 0..4 against the
// threshold registers; on battery, from the second measurement on, the level
// cannot rise above the previous one. Bad and low events, the full-charge
// counter and flag, and a level-changed event against the last reported level
// go out with the voltage in one response word. The response word is valid
// once the sample adder, the scale step, the divider loop and the finish step
// have run in that order. The next request is taken only back in idle, after
// the finish step; a response that is still waiting holds the finish step
// until it is taken. A request without start_request, or in firmware update
// mode, is accepted and gives no response. A finished response waits in its
// output register while the next request is taken. Configuration is to be
// written through the csr_ port while the block idles; the block itself does
// not enforce this.
module battery_level_monitor
   import blm_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_tvalid,
   output logic                   req_tready,
   // Fields from bit 0: ext_power, charge_done_pin, sample_a, sample_b,
   // sample_c, sample_d, sample_e, vref_sample, zero fill.
   input  logic [79:0]            req_tdata,
   // Fields from bit 0: start_request, fw_update_mode.
   input  logic [1:0]             req_tuser,

   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // Fields from bit 0: voltage_mv, level, level_changed, bad_event,
   // low_event, full_event, full_flag.
   output logic [23:0]            rsp_tdata,

   input  logic                   csr_wr_en,
   input  logic [CsrIdxWidth-1:0] csr_index,
   input  logic [MvWidth-1:0]     csr_wdata
);

   `include "assert_macros.svh"

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUM,
      ST_SCALE,
      ST_DIV,
      ST_DONE
   } state_type;

   // Configuration registers.
   mv_type    shutdown_ff, low_alarm_ff, level1_ff, level2_ff, level3_ff, full_ff;
   count_type full_cnt_pin_ff, full_cnt_ff;

   // Control and measurement state.
   state_type state_ff, state_in;
   logic [3:0] step_ff, step_in;
   logic       rsp_valid_ff, rsp_valid_in;
   level_type  last_level_ff, last_level_in;
   logic       first_done_ff, first_done_in;
   count_type  full_counter_ff, full_counter_in;
   logic       full_state_ff, full_state_in;
   level_type  reported_ff, reported_in;

   // Datapath.
   sample_type               samples_ff [NumSamples];
   sample_type               samples_in [NumSamples];
   sample_type               vref_ff, vref_in;
   logic                     ext_ff, ext_in;
   logic                     pin_ff, pin_in;
   logic [SumWidth-1:0]      sum_ff, sum_in;
   logic [SampleWidth-1:0]   rem_ff, rem_in;
   mv_type                   quot_ff, quot_in;
   logic                     sat_ff, sat_in;
   logic [23:0]              rsp_data_ff, rsp_data_in;

   logic                     accept;
   logic                     measure;
   logic [ScaledWidth-1:0]   scaled;
   logic [SampleWidth:0]     trial;
   logic                     trial_ge;
   logic [SampleWidth:0]     trial_diff;
   mv_type                   mv;
   level_type                lvl_raw, lvl;
   logic                     bad, low, fev, changed, at_full;
   count_type                cnt_inc;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign measure    = req_tuser[0] && !req_tuser[1];
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // sum * 480 = sum * 512 - sum * 32.
   assign scaled = {sum_ff, 9'b0} - {4'b0, sum_ff, 5'b0};

   // One restoring division step: the remainder stays below vref unless the result saturates.
   assign trial      = {rem_ff, quot_ff[MvWidth-1]};
   assign trial_ge   = (trial >= {1'b0, vref_ff});
   assign trial_diff = trial - {1'b0, vref_ff};

   // Finish stage: voltage, level and events.
   assign mv = sat_ff ? MV_MAX : quot_ff;

   always_comb begin
      if (mv >= full_ff) begin
         lvl_raw = LEVEL_4;
      end else if (mv >= level3_ff) begin
         lvl_raw = LEVEL_3;
      end else if (mv >= level2_ff) begin
         lvl_raw = LEVEL_2;
      end else if (mv >= level1_ff) begin
         lvl_raw = LEVEL_1;
      end else begin
         lvl_raw = LEVEL_0;
      end
   end

   assign lvl     = (!ext_ff && first_done_ff && (lvl_raw > last_level_ff)) ?
                    last_level_ff : lvl_raw;
   assign bad     = (mv < shutdown_ff);
   assign low     = !bad && (mv < low_alarm_ff);
   assign at_full = (mv >= full_ff);
   assign cnt_inc = (full_counter_ff == COUNT_MAX) ? COUNT_MAX : full_counter_ff + 8'd1;
   assign changed = (reported_ff != lvl);

   always_comb begin
      state_in        = state_ff;
      step_in         = step_ff;
      rsp_valid_in    = rsp_valid_ff;
      last_level_in   = last_level_ff;
      first_done_in   = first_done_ff;
      full_counter_in = full_counter_ff;
      full_state_in   = full_state_ff;
      reported_in     = reported_ff;
      samples_in      = samples_ff;
      vref_in         = vref_ff;
      ext_in          = ext_ff;
      pin_in          = pin_ff;
      sum_in          = sum_ff;
      rem_in          = rem_ff;
      quot_in         = quot_ff;
      sat_in          = sat_ff;
      rsp_data_in     = rsp_data_ff;
      fev             = 1'b0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept && measure) begin
               ext_in        = req_tdata[0];
               pin_in        = req_tdata[1];
               samples_in[0] = req_tdata[13:2];
               samples_in[1] = req_tdata[25:14];
               samples_in[2] = req_tdata[37:26];
               samples_in[3] = req_tdata[49:38];
               samples_in[4] = req_tdata[61:50];
               vref_in       = req_tdata[73:62];
               sum_in        = '0;
               step_in       = '0;
               state_in      = ST_SUM;
            end
         end
         ST_SUM: begin
            // Add the head of the sample line, then shift it along.
            sum_in = sum_ff + {3'b0, samples_ff[0]};
            for (int i = 0; i < NumSamples - 1; i++) begin
               samples_in[i] = samples_ff[i+1];
            end
            step_in = step_ff + 4'd1;
            if (step_ff == 4'(NumSamples - 1)) begin
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            // The quotient exceeds 16 bits exactly when the top byte reaches
            // vref; a zero vref lands here too.
            sat_in   = ({4'b0, scaled[ScaledWidth-1:MvWidth]} >= vref_ff);
            rem_in   = {4'b0, scaled[ScaledWidth-1:MvWidth]};
            quot_in  = scaled[MvWidth-1:0];
            step_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            rem_in  = trial_ge ? trial_diff[SampleWidth-1:0] : trial[SampleWidth-1:0];
            quot_in = {quot_ff[MvWidth-2:0], trial_ge};
            step_in = step_ff + 4'd1;
            if (step_ff == 4'(MvWidth - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               last_level_in = lvl;
               first_done_in = 1'b1;
               reported_in   = lvl;
               if (at_full) begin
                  if (ext_ff) begin
                     full_counter_in = cnt_inc;
                     if (((cnt_inc > full_cnt_pin_ff) && pin_ff) ||
                         (cnt_inc > full_cnt_ff)) begin
                        full_counter_in = '0;
                        if (!full_state_ff) begin
                           full_state_in = 1'b1;
                           fev           = 1'b1;
                        end
                     end
                  end
               end else begin
                  full_state_in = 1'b0;
               end
               rsp_data_in  = {full_state_in, fev, low, bad, changed, lvl, mv};
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         step_ff         <= '0;
         rsp_valid_ff    <= 1'b0;
         last_level_ff   <= LEVEL_0;
         first_done_ff   <= 1'b0;
         full_counter_ff <= '0;
         full_state_ff   <= 1'b0;
         reported_ff     <= LEVEL_NONE;
      end else begin
         state_ff        <= state_in;
         step_ff         <= step_in;
         rsp_valid_ff    <= rsp_valid_in;
         last_level_ff   <= last_level_in;
         first_done_ff   <= first_done_in;
         full_counter_ff <= full_counter_in;
         full_state_ff   <= full_state_in;
         reported_ff     <= reported_in;
      end
      samples_ff  <= samples_in;
      vref_ff     <= vref_in;
      ext_ff      <= ext_in;
      pin_ff      <= pin_in;
      sum_ff      <= sum_in;
      rem_ff      <= rem_in;
      quot_ff     <= quot_in;
      sat_ff      <= sat_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Configuration registers; values wider than a register are truncated.
   always_ff @(posedge clock) begin
      if (reset) begin
         shutdown_ff     <= RST_SHUTDOWN;
         low_alarm_ff    <= RST_LOW_ALARM;
         level1_ff       <= RST_LEVEL1;
         level2_ff       <= RST_LEVEL2;
         level3_ff       <= RST_LEVEL3;
         full_ff         <= RST_FULL;
         full_cnt_pin_ff <= RST_FULL_CNT_PIN;
         full_cnt_ff     <= RST_FULL_CNT;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_SHUTDOWN:     shutdown_ff     <= csr_wdata;
            CSR_LOW_ALARM:    low_alarm_ff    <= csr_wdata;
            CSR_LEVEL1:       level1_ff       <= csr_wdata;
            CSR_LEVEL2:       level2_ff       <= csr_wdata;
            CSR_LEVEL3:       level3_ff       <= csr_wdata;
            CSR_FULL:         full_ff         <= csr_wdata;
            CSR_FULL_CNT_PIN: full_cnt_pin_ff <= csr_wdata[CountWidth-1:0];
            CSR_FULL_CNT:     full_cnt_ff     <= csr_wdata[CountWidth-1:0];
            default: begin
            end
         endcase
      end
   end

   // A reported level never goes above level 4.
   `ASSERT_IMPLIES(a_level_range, clock, reset, rsp_tvalid, rsp_tdata[18:16] <= LEVEL_4)
   // A full event always comes with the full flag set.
   `ASSERT_IMPLIES(a_full_event_flag, clock, reset, rsp_tvalid && rsp_tdata[22], rsp_tdata[23])
   // Bad and low events exclude each other.
   `ASSERT_IMPLIES(a_bad_low_excl, clock, reset, rsp_tvalid, !(rsp_tdata[20] && rsp_tdata[21]))
   // An ignored request leaves the block ready for the next one.
   `ASSERT_NEXT(a_ignored_idle, clock, reset, req_tvalid && req_tready && !measure, req_tready)

endmodule
